// ===== hw/rtl/ssr_pkg.sv =====
// shared types, constants and register codes of the setpoint schedule ramp unit
// no dependencies; imported by every module of the block
package ssr_pkg;

  // number of daily program timepoints held in storage
  localparam int MaxTp   = 4;
  localparam int TpIdxW  = (MaxTp > 1) ? $clog2(MaxTp) : 1;
  localparam int CntW    = $clog2(MaxTp + 1);
  localparam int ProgW   = (CntW > 3) ? CntW : 3;

  // time key is {hour, minute}
  localparam int KeyW    = 11;

  // ramp timer
  localparam int TimerW  = 23;
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam int PeriodW = 22;
  localparam logic [PeriodW-1:0] PeriodReset = 22'd300000;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 27;
  localparam int NumTpRegs = 4;
  localparam logic [CfgIdxW-1:0] CfgActive = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTp0    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod = 3'd5;
  localparam logic [2:0] ActiveReset = 3'd4;

  // operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // one timepoint register as packed
  typedef struct packed {
    logic signed [7:0] heat;
    logic signed [7:0] cool;
    logic [5:0]        minute;
    logic [4:0]        hour;
  } tp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             op;
    logic             match_valid;
    logic [ProgW-1:0] match_prog;
    logic [15:0]      elapsed;
  } qent_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/ssr_front.sv =====
// front end: accepts items and classifies the time of day against the timepoints
// depends on ssr_pkg
module ssr_front import ssr_pkg::*; (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [4:0]            hour_i,
  input  logic [5:0]            minute_i,
  input  logic [15:0]           elapsed_ms_i,
  input  logic [2:0]            active_tp_i,
  input  tp_t  [MaxTp-1:0]      tp_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output qent_t                 push_data_o
);

  logic [KeyW-1:0]   now;
  logic [KeyW-1:0]   key [MaxTp];
  logic [CntW-1:0]   n_use;
  logic [CntW-1:0]   n_m1;
  logic [TpIdxW-1:0] last_idx;
  logic              found;
  logic [ProgW-1:0]  prog;

  assign now = {hour_i, minute_i};

  // timepoint keys
  always_comb begin
    for (int i = 0; i < MaxTp; i++) begin
      key[i] = {tp_i[i].hour, tp_i[i].minute};
    end
  end

  // clamp the count in use to one .. MaxTp
  always_comb begin
    if (active_tp_i == 3'd0) begin
      n_use = CntW'(1);
    end else if (int'(active_tp_i) > MaxTp) begin
      n_use = CntW'(MaxTp);
    end else begin
      n_use = CntW'(active_tp_i);
    end
  end

  assign n_m1     = n_use - CntW'(1);
  assign last_idx = n_m1[TpIdxW-1:0];

  // half-open interval search, later matches win, wrap interval last
  always_comb begin
    found = 1'b0;
    prog  = '0;
    for (int y = 0; y < MaxTp - 1; y++) begin
      if (CntW'(y + 1) < n_use && now >= key[y] && now < key[y + 1]) begin
        found = 1'b1;
        prog  = ProgW'(y + 1);
      end
    end
    if (now >= key[last_idx] || now < key[0]) begin
      found = 1'b1;
      prog  = ProgW'(n_use);
    end
  end

  assign push_valid_o            = in_valid_i;
  assign in_ready_o              = push_ready_i;
  assign push_data_o.op          = operation_i;
  assign push_data_o.match_valid = found;
  assign push_data_o.match_prog  = prog;
  assign push_data_o.elapsed     = elapsed_ms_i;

endmodule

// ===== hw/rtl/ssr_queue.sv =====
// short fifo of classified items between front and back
// depends on ssr_pkg
module ssr_queue import ssr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  qent_t   push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output qent_t   pop_data_o,
  output q_stat_t stat_o
);

  qent_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign push_ready_o = !stat_o.full;
  assign pop_valid_o  = !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ssr_back.sv =====
// back end: program state, setpoint load and ramp, result register
// depends on ssr_pkg
module ssr_back import ssr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  qent_t              pop_data_i,
  input  tp_t  [MaxTp-1:0]   tp_i,
  input  logic [PeriodW-1:0] period_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         program_res_o,
  output logic signed [7:0]  cooling_setpoint_o,
  output logic signed [7:0]  heating_setpoint_o,
  output logic               ramp_moved_o
);

  logic [ProgW-1:0]  prog_q, prog_d;
  logic signed [7:0] cool_q, cool_d;
  logic signed [7:0] heat_q, heat_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic              moved_d;
  logic              out_valid_q;
  logic [ProgW-1:0]  res_prog_q;
  logic signed [7:0] res_cool_q, res_heat_q;
  logic              res_moved_q;
  logic              fire;
  logic [ProgW-1:0]  prog_m1;
  tp_t               tp_sel;
  logic [TimerW:0]   sum;
  logic [TimerW-1:0] timer_sat;

  // output register frees up when empty or being taken
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;

  // program choice and target lookup
  assign prog_d  = pop_data_i.match_valid ? pop_data_i.match_prog : prog_q;
  assign prog_m1 = prog_d - ProgW'(1);
  assign tp_sel  = tp_i[prog_m1[TpIdxW-1:0]];

  // saturating timer add
  assign sum       = {1'b0, timer_q} + (TimerW + 1)'(pop_data_i.elapsed);
  assign timer_sat = sum[TimerW] ? TimerMax : sum[TimerW-1:0];

  // start load or ramp step
  always_comb begin
    cool_d  = cool_q;
    heat_d  = heat_q;
    timer_d = timer_sat;
    moved_d = 1'b0;
    if (pop_data_i.op == OpStart) begin
      cool_d  = tp_sel.cool;
      heat_d  = tp_sel.heat;
      timer_d = '0;
    end else if (timer_sat > TimerW'(period_i)) begin
      timer_d = '0;
      moved_d = 1'b1;
      if (tp_sel.cool > cool_q) begin
        cool_d = cool_q + 8'sd1;
      end else if (tp_sel.cool < cool_q) begin
        cool_d = cool_q - 8'sd1;
      end
      if (tp_sel.heat > heat_q) begin
        heat_d = heat_q + 8'sd1;
      end else if (tp_sel.heat < heat_q) begin
        heat_d = heat_q - 8'sd1;
      end
    end
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q      <= ProgW'(1);
      cool_q      <= '0;
      heat_q      <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        prog_q  <= prog_d;
        cool_q  <= cool_d;
        heat_q  <= heat_d;
        timer_q <= timer_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_prog_q  <= prog_d;
      res_cool_q  <= cool_d;
      res_heat_q  <= heat_d;
      res_moved_q <= moved_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign program_res_o      = res_prog_q[2:0];
  assign cooling_setpoint_o = res_cool_q;
  assign heating_setpoint_o = res_heat_q;
  assign ramp_moved_o       = res_moved_q;

endmodule

// ===== hw/rtl/setpoint_schedule_ramp_unit.sv =====
// Setpoint schedule ramp unit: time-of-day program selection with a slow
// half-degree setpoint ramp. Depends on ssr_pkg, ssr_front, ssr_queue, ssr_back.
//
// Usage:
//  - input channel (in_valid_i/in_ready_o): operation, hour, minute and
//    elapsed milliseconds; each item gives exactly one result item.
//  - output channel (out_valid_o/out_ready_i): active program, cooling and
//    heating setpoints in half degrees and the ramp-moved flag.
//  - config channel (cfg_valid_i/cfg_ready_o): register index and data,
//    always ready; write only while no item is in flight.
//  - result path: an accepted item is written into the queue entry, then
//    popped into the result register, from which the receiver takes it.
//  - throughput: one item per cycle while results are taken; the back end
//    state update (program, setpoints, timer) is one registered step per pop.
//  - receiver stall: the result register holds, the two-entry queue fills,
//    then in_ready_o drops; it rises again as soon as a result is taken.
//  - reset: program 1, setpoints 0, timer 0, four timepoints in use, all
//    timepoints zero, ramp period 300000 ms; the block is ready at once.
module setpoint_schedule_ramp_unit import ssr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [4:0]          hour_i,
  input  logic [5:0]          minute_i,
  input  logic [15:0]         elapsed_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          program_res_o,
  output logic signed [7:0]   cooling_setpoint_o,
  output logic signed [7:0]   heating_setpoint_o,
  output logic                ramp_moved_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [2:0]         active_tp_q;
  tp_t  [MaxTp-1:0]   tp_q;
  logic [PeriodW-1:0] period_q;
  logic               cfg_we;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  qent_t              push_data, pop_data;
  q_stat_t            q_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_tp_q <= ActiveReset;
      tp_q        <= '0;
      period_q    <= PeriodReset;
    end else if (cfg_we) begin
      if (cfg_index_i == CfgActive) begin
        active_tp_q <= cfg_data_i[2:0];
      end
      if (cfg_index_i == CfgPeriod) begin
        period_q <= cfg_data_i[PeriodW-1:0];
      end
      for (int i = 0; i < MaxTp; i++) begin
        if (i < NumTpRegs && cfg_index_i == CfgIdxW'(int'(CfgTp0) + i)) begin
          tp_q[i] <= tp_t'(cfg_data_i);
        end
      end
    end
  end

  ssr_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .elapsed_ms_i (elapsed_ms_i),
    .active_tp_i  (active_tp_q),
    .tp_i         (tp_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ssr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .stat_o       (q_stat)
  );

  ssr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .pop_ready_o        (pop_ready),
    .pop_data_i         (pop_data),
    .tp_i               (tp_q),
    .period_i           (period_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .program_res_o      (program_res_o),
    .cooling_setpoint_o (cooling_setpoint_o),
    .heating_setpoint_o (heating_setpoint_o),
    .ramp_moved_o       (ramp_moved_o)
  );

  // a delivered result is never program zero
  a_prog_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> program_res_o != 3'd0)
    else $error("program result is zero");

  // queue cannot be full and empty at once
  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // a taken result with nothing queued leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !pop_valid) |=> !out_valid_o)
    else $error("result repeated after being taken");

  // a full queue with a stalled receiver holds the input off next cycle
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && out_valid_o && !out_ready_i) |=> !in_ready_o)
    else $error("input accepted while queue and output are stalled");

endmodule

// ===== test/setpoint_schedule_ramp_unit_tb.sv =====
// self-checking testbench for the setpoint schedule ramp unit: directed and random items,
// each result checked against an in-bench predictor of program choice and setpoint ramp
// depends on ssr_pkg and setpoint_schedule_ramp_unit
`timescale 1ns / 100ps

module setpoint_schedule_ramp_unit_tb;
  import ssr_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 160;

  // one result item as the predictor sees it
  typedef struct packed {
    logic [2:0]        prog;
    logic signed [7:0] cool;
    logic signed [7:0] heat;
    logic              moved;
  } setpoint_res_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                operation;
  logic [4:0]          hour;
  logic [5:0]          minute;
  logic [15:0]         elapsed_ms;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          program_res;
  logic signed [7:0]   cooling;
  logic signed [7:0]   heating;
  logic                ramp_moved;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // predictor copy of configuration and state
  logic [2:0]          sched_active;
  tp_t                 sched_tp [MaxTp];
  logic [PeriodW-1:0]  sched_period;
  logic [2:0]          sched_prog;
  logic signed [7:0]   sched_cool;
  logic signed [7:0]   sched_heat;
  logic [TimerW-1:0]   sched_timer;

  setpoint_res_t       sp_expected [$];
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  int                  in_idle_pct = 0;
  int                  out_idle_pct = 0;
  int                  hold_req = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;

  setpoint_schedule_ramp_unit u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (operation),
    .hour_i             (hour),
    .minute_i           (minute),
    .elapsed_ms_i       (elapsed_ms),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .program_res_o      (program_res),
    .cooling_setpoint_o (cooling),
    .heating_setpoint_o (heating),
    .ramp_moved_o       (ramp_moved),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tp_t make_tp(logic [4:0] h, logic [5:0] m, logic signed [7:0] c,
                                  logic signed [7:0] ht);
    tp_t r;
    r.hour   = h;
    r.minute = m;
    r.cool   = c;
    r.heat   = ht;
    return r;
  endfunction

  function automatic logic [KeyW-1:0] time_key(tp_t tp);
    return {tp.hour, tp.minute};
  endfunction

  // one half-degree move toward the target, none when already there
  function automatic logic signed [7:0] step_toward(logic signed [7:0] cur,
                                                    logic signed [7:0] target);
    if (target > cur) return cur + 8'sd1;
    if (target < cur) return cur - 8'sd1;
    return cur;
  endfunction

  task automatic reset_schedule();
    sched_active = ActiveReset;
    for (int i = 0; i < MaxTp; i++) sched_tp[i] = '0;
    sched_period = PeriodReset;
    sched_prog   = 3'd1;
    sched_cool   = '0;
    sched_heat   = '0;
    sched_timer  = '0;
  endtask

  // program choice, then load or ramp; updates the predictor state
  function automatic setpoint_res_t predict_setpoints(logic op, logic [4:0] h, logic [5:0] m,
                                                      logic [15:0] e);
    int            n;
    logic [KeyW-1:0] now;
    tp_t           tp;
    logic [TimerW:0] sum;
    setpoint_res_t r;
    n = (sched_active < 3'd1) ? 1 : (int'(sched_active) > MaxTp) ? MaxTp : int'(sched_active);
    now = {h, m};
    for (int y = 0; y + 1 < n; y++) begin
      if (now >= time_key(sched_tp[y]) && now < time_key(sched_tp[y+1])) sched_prog = 3'(y + 1);
    end
    if (now >= time_key(sched_tp[n-1]) || now < time_key(sched_tp[0])) sched_prog = 3'(n);
    tp = sched_tp[(int'(sched_prog) + MaxTp - 1) % MaxTp];
    r.moved = 1'b0;
    if (op == OpStart) begin
      sched_cool  = tp.cool;
      sched_heat  = tp.heat;
      sched_timer = '0;
    end else begin
      sum = {1'b0, sched_timer} + (TimerW + 1)'(e);
      if (sum > (TimerW + 1)'(TimerMax)) sum = (TimerW + 1)'(TimerMax);
      sched_timer = sum[TimerW-1:0];
      if (sched_timer > TimerW'(sched_period)) begin
        sched_cool  = step_toward(sched_cool, tp.cool);
        sched_heat  = step_toward(sched_heat, tp.heat);
        sched_timer = '0;
        r.moved     = 1'b1;
      end
    end
    r.prog = sched_prog;
    r.cool = sched_cool;
    r.heat = sched_heat;
    return r;
  endfunction

  // predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    setpoint_res_t want;
    setpoint_res_t got;
    if (in_valid && in_ready) begin
      sp_expected.push_back(predict_setpoints(operation, hour, minute, elapsed_ms));
    end
    if (out_valid && out_ready) begin
      got = '{prog: program_res, cool: cooling, heat: heating, moved: ramp_moved};
      if (sp_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: prog %0d cool %0d heat %0d moved %0d",
                   got.prog, got.cool, got.heat, got.moved);
      end else begin
        want = sp_expected.pop_front();
        if (got.prog !== want.prog || got.cool !== want.cool ||
            got.heat !== want.heat || got.moved !== want.moved) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected prog %0d cool %0d heat %0d moved %0d,",
                      " got prog %0d cool %0d heat %0d moved %0d"},
                     want.prog, want.cool, want.heat, want.moved,
                     got.prog, got.cool, got.heat, got.moved);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("** setpoint_schedule_ramp_unit: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // send one item; returns at a falling edge with valid still high
  task automatic send_item(logic op, logic [4:0] h, logic [5:0] m, logic [15:0] e);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    hour       <= h;
    minute     <= m;
    elapsed_ms <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // register write, mirrored into the predictor at the accepting edge
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgActive) begin
      sched_active = data[2:0];
    end else if (idx >= CfgTp0 && int'(idx) < int'(CfgTp0) + NumTpRegs) begin
      if (int'(idx - CfgTp0) < MaxTp) sched_tp[int'(idx - CfgTp0)] = data;
    end else if (idx == CfgPeriod) begin
      sched_period = data[PeriodW-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait until every result is in
  task automatic settle();
    in_valid <= 1'b0;
    while (sp_expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // reset values: all timepoints zero, four in use, 300000 ms ramp period
  task automatic test_reset_defaults();
    send_item(OpStart, 5'd0, 6'd0, 16'd0);
    repeat (5) send_item(OpStep, 5'd23, 6'd59, 16'hFFFF);
    send_item(OpStart, 5'd31, 6'd63, 16'hFFFF);
  endtask

  // ordered schedule with extreme setpoints; boundaries, wrap and odd times
  task automatic test_schedule_edges();
    settle();
    cfg_write(CfgPeriod, '0);
    cfg_write(CfgTp0,        make_tp(5'd6,  6'd0,  8'sd127, -8'sd128));
    cfg_write(CfgTp0 + 3'd1, make_tp(5'd12, 6'd30, -8'sd128, 8'sd127));
    cfg_write(CfgTp0 + 3'd2, make_tp(5'd18, 6'd0,  8'sd40,  8'sd30));
    cfg_write(CfgTp0 + 3'd3, make_tp(5'd22, 6'd45, -8'sd1,  8'sd0));
    cfg_write(CfgActive, CfgDataW'(3'd4));
    send_item(OpStart, 5'd6,  6'd0,  16'd0);
    send_item(OpStep,  5'd12, 6'd29, 16'd1);
    send_item(OpStep,  5'd12, 6'd30, 16'd1);
    send_item(OpStep,  5'd5,  6'd59, 16'd0);
    send_item(OpStart, 5'd22, 6'd45, 16'd7);
    send_item(OpStart, 5'd31, 6'd63, 16'd0);
    send_item(OpStart, 5'd0,  6'd0,  16'd0);
    send_item(OpStep,  5'd18, 6'd0,  16'hFFFF);
    send_item(OpStep,  5'd17, 6'd59, 16'd2);
  endtask

  // single timepoint, count of zero, count above the store, unused indexes
  task automatic test_program_count();
    settle();
    cfg_write(CfgActive, CfgDataW'(3'd1));
    cfg_write(CfgPeriod, CfgDataW'({PeriodW{1'b1}}));
    send_item(OpStart, 5'd0,  6'd0,  16'd0);
    send_item(OpStep,  5'd23, 6'd59, 16'hFFFF);
    settle();
    cfg_write(CfgActive, CfgDataW'(3'd0));
    cfg_write(3'd6, CfgDataW'($urandom));
    cfg_write(3'd7, CfgDataW'($urandom));
    send_item(OpStep,  5'd12, 6'd0,  16'd100);
    settle();
    cfg_write(CfgActive, CfgDataW'(3'd7));
    cfg_write(CfgPeriod, CfgDataW'(PeriodReset));
    send_item(OpStart, 5'd20, 6'd0,  16'd0);
    send_item(OpStep,  5'd23, 6'd0,  16'hFFFF);
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_back_pressure();
    int saved_pct;
    settle();
    saved_pct   = in_idle_pct;
    in_idle_pct = 0;
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    repeat (40) send_item(OpStep, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                          16'($urandom));
    in_idle_pct = saved_pct;
  endtask

  task automatic random_schedule();
    logic [KeyW-1:0] keys [MaxTp];
    logic [KeyW-1:0] swap;
    int              pick;
    if ($urandom_range(99) < 80) cfg_write(CfgActive, CfgDataW'($urandom_range(1, 4)));
    else cfg_write(CfgActive, CfgDataW'($urandom_range(0, 7)));
    if ($urandom_range(99) < 70) begin
      // sorted timepoints, the usual daily program
      for (int i = 0; i < MaxTp; i++)
        keys[i] = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
      for (int i = 0; i < MaxTp - 1; i++) begin
        for (int j = 0; j < MaxTp - 1 - i; j++) begin
          if (keys[j] > keys[j+1]) begin
            swap      = keys[j];
            keys[j]   = keys[j+1];
            keys[j+1] = swap;
          end
        end
      end
      for (int i = 0; i < NumTpRegs; i++)
        cfg_write(CfgTp0 + 3'(i), make_tp(keys[i][10:6], keys[i][5:0], 8'($urandom),
                                           8'($urandom)));
    end else begin
      for (int i = 0; i < NumTpRegs; i++) cfg_write(CfgTp0 + 3'(i), CfgDataW'($urandom));
    end
    pick = $urandom_range(0, 5);
    case (pick)
      0: cfg_write(CfgPeriod, '0);
      1: cfg_write(CfgPeriod, CfgDataW'($urandom_range(0, 1000)));
      2: cfg_write(CfgPeriod, CfgDataW'($urandom_range(0, 200000)));
      3: cfg_write(CfgPeriod, CfgDataW'(PeriodReset));
      4: cfg_write(CfgPeriod, CfgDataW'({PeriodW{1'b1}}));
      default: cfg_write(CfgPeriod, CfgDataW'($urandom));
    endcase
    if ($urandom_range(99) < 10) cfg_write(3'($urandom_range(6, 7)), CfgDataW'($urandom));
  endtask

  // bursts of random items, each under a fresh random schedule
  task automatic test_random_traffic(int count);
    int          sent;
    int          burst;
    int          pick;
    logic        op;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [15:0] e;
    sent = 0;
    while (sent < count) begin
      settle();
      random_schedule();
      burst = $urandom_range(40, 120);
      if (burst > count - sent) burst = count - sent;
      repeat (burst) begin
        op = ($urandom_range(99) < 15) ? OpStart : OpStep;
        h  = ($urandom_range(99) < 90) ? 5'($urandom_range(0, 23)) : 5'($urandom_range(24, 31));
        m  = ($urandom_range(99) < 90) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(60, 63));
        pick = $urandom_range(0, 9);
        if (pick < 4)      e = 16'($urandom);
        else if (pick < 7) e = 16'($urandom_range(0, 2000));
        else if (pick < 9) e = 16'hFFFF;
        else               e = '0;
        send_item(op, h, m, e);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    operation  = OpStart;
    hour       = '0;
    minute     = '0;
    elapsed_ms = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CfgActive;
    cfg_data   = '0;
    in_idle_pct  = 9;
    out_idle_pct = 65;
    reset_schedule();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_schedule_edges();
    test_program_count();
    test_back_pressure();
    test_random_traffic(430);
    in_idle_pct  = 65;
    out_idle_pct = 9;
    test_random_traffic(430);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(430);
    settle();

    if (mismatches == 0) begin
      $display("** setpoint_schedule_ramp_unit: PASSED **");
    end else begin
      $display("** setpoint_schedule_ramp_unit: FAILED **");
    end
    $finish;
  end

endmodule
